/* rtl/ple_pkg.sv */
// package for the positional list engine
// types, codes and default sizes shared by the interfaces, cells, tree and top level
// no dependencies
package ple_pkg;

    localparam int POS_W        = 7;
    localparam int OP_W         = 2;
    localparam int VAL_W        = 32;
    localparam int CNT_OUT_W    = 7;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 64;
    localparam int DEF_DATA_W   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_MOVE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_APPLY,
        S_REDUCE,
        S_DONE
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic apply;
        op_t  op;
    } ctrl_t;

endpackage

/* rtl/ple_if.sv */
// valid/ready channel interfaces for command and response beats
// depends on ple_pkg
interface ple_cmd_if
    import ple_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

interface ple_rsp_if
    import ple_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic signed [VAL_W-1:0] largest_value;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, output read_value, output entry_count,
                    output largest_value, output status, input ready);
    modport sink   (input valid, input read_value, input entry_count,
                    input largest_value, input status, output ready);
endinterface

/* rtl/ple_cell.sv */
// one list cell: holds a single entry and shifts with its neighbours
// depends on ple_pkg
module ple_cell
    import ple_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_W,
    parameter int CMP_W      = 8,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  ctrl_t                 ctrl,
    input  logic [CMP_W-1:0]      pos,
    input  logic [CMP_W-1:0]      count,
    input  logic [CMP_W-1:0]      last,
    input  logic [DATA_WIDTH-1:0] load,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] entry,
    output logic                  occupied,
    output logic                  hit
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  at_or_above;
    logic                  below_last;

    assign at_or_above = (IDX >= pos);
    assign below_last  = (IDX < last);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.apply)
        begin
            case (ctrl.op)
                OP_INSERT:
                begin
                    if (IDX == pos)
                        entry_next = load;
                    else if (IDX > pos)
                        entry_next = left;
                end
                OP_REMOVE:
                begin
                    if (at_or_above && below_last)
                        entry_next = right;
                end
                OP_MOVE:
                begin
                    if (IDX == last)
                        entry_next = load;
                    else if (at_or_above && below_last)
                        entry_next = right;
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign occupied = (IDX < count);
    assign hit      = (IDX == pos) && (IDX < count);

endmodule

/* rtl/ple_tree.sv */
// registered reduction tree over the cells: signed maximum and selected entry
// one register level per tree level; depends on ple_pkg
module ple_tree
    import ple_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DATA_WIDTH-1:0] leaf_value [CAPACITY],
    input  logic                  leaf_valid [CAPACITY],
    input  logic                  leaf_hit   [CAPACITY],
    output logic                  max_valid,
    output logic [DATA_WIDTH-1:0] max_value,
    output logic [DATA_WIDTH-1:0] sel_value
);

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int NODES  = 1 << LEVELS;

    logic                  node_v_reg   [NODES];
    logic [DATA_WIDTH-1:0] node_max_reg [NODES];
    logic [DATA_WIDTH-1:0] node_sel_reg [NODES];

    logic                  pad_v   [NODES];
    logic [DATA_WIDTH-1:0] pad_val [NODES];
    logic [DATA_WIDTH-1:0] pad_sel [NODES];

    genvar j, i;

    // leaves padded up to a power of two
    generate
        for (j = 0; j < NODES; j++)
        begin : g_leaf
            if (j < CAPACITY)
            begin : g_real
                assign pad_v[j]   = leaf_valid[j];
                assign pad_val[j] = leaf_value[j];
                assign pad_sel[j] = leaf_hit[j] ? leaf_value[j] : '0;
            end
            else
            begin : g_pad
                assign pad_v[j]   = 1'b0;
                assign pad_val[j] = '0;
                assign pad_sel[j] = '0;
            end
        end

        for (i = 1; i < NODES; i++)
        begin : g_node
            logic                  a_v, b_v;
            logic [DATA_WIDTH-1:0] a_val, b_val, a_sel, b_sel;

            if (2 * i >= NODES)
            begin : g_from_leaf
                assign a_v   = pad_v[2*i-NODES];
                assign a_val = pad_val[2*i-NODES];
                assign a_sel = pad_sel[2*i-NODES];
                assign b_v   = pad_v[2*i+1-NODES];
                assign b_val = pad_val[2*i+1-NODES];
                assign b_sel = pad_sel[2*i+1-NODES];
            end
            else
            begin : g_from_node
                assign a_v   = node_v_reg[2*i];
                assign a_val = node_max_reg[2*i];
                assign a_sel = node_sel_reg[2*i];
                assign b_v   = node_v_reg[2*i+1];
                assign b_val = node_max_reg[2*i+1];
                assign b_sel = node_sel_reg[2*i+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    node_v_reg[i] <= 1'b0;
                else
                    node_v_reg[i] <= a_v | b_v;
            end

            always_ff @(posedge clk)
            begin
                node_sel_reg[i] <= a_sel | b_sel;
                if (a_v && b_v)
                    node_max_reg[i] <= ($signed(a_val) > $signed(b_val)) ? a_val : b_val;
                else if (a_v)
                    node_max_reg[i] <= a_val;
                else
                    node_max_reg[i] <= b_val;
            end
        end
    endgenerate

    // slot zero of the node arrays is unused by the tree
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_v_reg[0] <= 1'b0;
        else
            node_v_reg[0] <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        node_max_reg[0] <= '0;
        node_sel_reg[0] <= '0;
    end

    assign max_valid = node_v_reg[1] | node_v_reg[0];
    assign max_value = node_max_reg[1] | node_max_reg[0];
    assign sel_value = node_sel_reg[1] | node_sel_reg[0];

endmodule

/* rtl/positional_list_engine_unit.sv */
// top level of the positional list engine
// depends on ple_pkg, ple_if (ple_cmd_if, ple_rsp_if), ple_cell and ple_tree
//
// usage
// - cmd carries one beat per operation: insert, remove, query or move to end,
//   a list position and a value (used by insert only)
// - rsp returns one beat per command: the queried entry (-1 on a failed query,
//   0 for other operations), the entry count, the largest entry (-1 when the
//   list is empty) and a status code (ok, out of range, full, empty)
// - a bad request leaves the list untouched and is reported in status
// - the list lives in a row of CAPACITY cells; insert, remove and move shift
//   the cells at or above the position by one place, all at once in the apply state
// - a registered tree of depth log2(CAPACITY) over the cells reads the entry
//   at the position and finds the largest entry; each command walks it twice
// - after the accepting edge a command waits for the tree in fetch, is
//   applied, waits for the tree again in reduce and then offers its response
//   beat; the tree depth sets how long each wait lasts
// - cmd.ready is high only while no command is in flight; the response is
//   held in registers until rsp.ready, so a stalled receiver simply holds
//   off the next command
// - after reset the list is empty; entries need no clearing as only entries
//   below the count are ever read
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_W
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_cmd_if.sink   cmd,
    ple_rsp_if.source rsp
);

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WAIT_W = $clog2(LEVELS + 1);
    localparam logic [WAIT_W-1:0] WAIT_FULL = WAIT_W'(LEVELS);
    localparam logic [WAIT_W-1:0] WAIT_ONE  = WAIT_W'(1);
    localparam logic [CMP_W-1:0]  CAP_CMP   = CMP_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [WAIT_W-1:0]     wait_reg, wait_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    op_t                   op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [VAL_W-1:0]      read_reg, read_next;
    status_t               status_reg, status_next;

    ctrl_t                 ctrl;
    logic [CMP_W-1:0]      pos_cmp, count_cmp, last_cmp;
    logic [DATA_WIDTH-1:0] load;
    logic signed [63:0]    value_wide;
    logic signed [63:0]    sel_wide;
    logic signed [63:0]    max_wide;

    logic [DATA_WIDTH-1:0] cell_entry [CAPACITY];
    logic                  cell_occ   [CAPACITY];
    logic                  cell_hit   [CAPACITY];

    logic                  max_valid;
    logic [DATA_WIDTH-1:0] max_value;
    logic [DATA_WIDTH-1:0] sel_value;

    logic cmd_beat;

    assign cmd_beat = cmd.valid && cmd.ready;

    // input value: sign-extend then cut to the entry width
    assign value_wide = 64'(cmd.value);

    assign pos_cmp   = CMP_W'(pos_reg);
    assign count_cmp = CMP_W'(count_reg);
    assign last_cmp  = count_cmp - CMP_W'(1);

    // insert loads the new value, move loads the entry fetched from the tree
    assign load = (op_reg == OP_INSERT) ? value_reg : sel_value;

    // -------------------------------------------------------------------------
    // row of cells
    // -------------------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_in;
            logic [DATA_WIDTH-1:0] right_in;

            if (k == 0)
            begin : g_first
                assign left_in = load;
            end
            else
            begin : g_mid_l
                assign left_in = cell_entry[k-1];
            end

            if (k == CAPACITY - 1)
            begin : g_final
                assign right_in = load;
            end
            else
            begin : g_mid_r
                assign right_in = cell_entry[k+1];
            end

            ple_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CMP_W      (CMP_W),
                .INDEX      (k)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .pos      (pos_cmp),
                .count    (count_cmp),
                .last     (last_cmp),
                .load     (load),
                .left     (left_in),
                .right    (right_in),
                .entry    (cell_entry[k]),
                .occupied (cell_occ[k]),
                .hit      (cell_hit[k])
            );
        end
    endgenerate

    // -------------------------------------------------------------------------
    // reduction tree: largest entry and entry at the position
    // -------------------------------------------------------------------------
    ple_tree #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaf_value (cell_entry),
        .leaf_valid (cell_occ),
        .leaf_hit   (cell_hit),
        .max_valid  (max_valid),
        .max_value  (max_value),
        .sel_value  (sel_value)
    );

    // tree words back to 32-bit patterns, sign-extended first
    assign sel_wide = 64'($signed(sel_value));
    assign max_wide = 64'($signed(max_value));

    // -------------------------------------------------------------------------
    // sequencer
    // -------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            count_reg <= count_next;
        end
    end

    // beat payload and response registers
    always_ff @(posedge clk)
    begin
        if (cmd_beat)
        begin
            op_reg    <= op_t'(cmd.operation);
            pos_reg   <= cmd.position;
            value_reg <= value_wide[DATA_WIDTH-1:0];
        end
        read_reg   <= read_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        count_next  = count_reg;
        read_next   = read_reg;
        status_next = status_reg;
        ctrl.apply  = 1'b0;
        ctrl.op     = op_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_beat)
                begin
                    wait_next  = WAIT_FULL;
                    state_next = S_FETCH;
                end
            end

            // wait for the tree to settle on the entry at the position
            S_FETCH:
            begin
                wait_next = wait_reg - WAIT_ONE;
                if (wait_reg == WAIT_ONE)
                    state_next = S_APPLY;
            end

            // check the request, update count and cells together in this state
            S_APPLY:
            begin
                status_next = ST_OK;
                read_next   = '0;
                if (op_reg == OP_INSERT)
                begin
                    if (count_cmp == CAP_CMP)
                        status_next = ST_FULL;
                    else if (pos_cmp > count_cmp)
                        status_next = ST_RANGE;
                    else
                    begin
                        ctrl.apply = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                    if (op_reg == OP_QUERY)
                        read_next = '1;
                end
                else if (pos_cmp >= count_cmp)
                begin
                    status_next = ST_RANGE;
                    if (op_reg == OP_QUERY)
                        read_next = '1;
                end
                else if (op_reg == OP_QUERY)
                begin
                    read_next = sel_wide[VAL_W-1:0];
                end
                else
                begin
                    ctrl.apply = 1'b1;
                    if (op_reg == OP_REMOVE)
                        count_next = count_reg - CNT_W'(1);
                end
                wait_next  = WAIT_FULL;
                state_next = S_REDUCE;
            end

            // wait for the tree to settle on the new largest entry
            S_REDUCE:
            begin
                wait_next = wait_reg - WAIT_ONE;
                if (wait_reg == WAIT_ONE)
                    state_next = S_DONE;
            end

            S_DONE:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // -------------------------------------------------------------------------
    // channel outputs
    // -------------------------------------------------------------------------
    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = (state_reg == S_DONE);
    assign rsp.read_value    = read_reg;
    assign rsp.entry_count   = CNT_OUT_W'(count_reg);
    assign rsp.largest_value = max_valid ? max_wide[VAL_W-1:0] : '1;
    assign rsp.status        = status_reg;

endmodule

/* verif/list_engine_checker.sv */
`timescale 1ns / 100ps
// scoreboard for the positional list engine: keeps a mirror of the list,
// predicts one response beat per command beat and compares field by field
// depends on ple_pkg and the ple_cmd_if / ple_rsp_if interfaces
module list_engine_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    ple_cmd_if   cmd,
    ple_rsp_if   rsp,
    output int   fail_count,
    output int   pending_count
);

    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic signed [VAL_W-1:0] largest_value;
        status_t                 status;
    } rsp_beat_t;

    logic signed [VAL_W-1:0] list_mem [CAPACITY];
    int                      list_len;
    rsp_beat_t               expected_rsp_q [$];

    initial
    begin
        list_len      = 0;
        fail_count    = 0;
        pending_count = 0;
    end

    // mirror update for one command, returns the response it should produce
    function automatic rsp_beat_t apply_list_op(input op_t op, input logic [POS_W-1:0] position,
                                                input logic signed [VAL_W-1:0] value);
        rsp_beat_t               beat;
        int                      p;
        logic signed [VAL_W-1:0] held;
        logic signed [VAL_W-1:0] best;
        p               = int'(position);
        beat.read_value = '0;
        beat.status     = ST_OK;
        if (op == OP_INSERT)
        begin
            if (list_len >= CAPACITY)
                beat.status = ST_FULL;
            else if (p > list_len)
                beat.status = ST_RANGE;
            else
            begin
                for (int k = list_len; k > p; k--)
                    list_mem[k] = list_mem[k-1];
                list_mem[p] = value;
                list_len++;
            end
        end
        else if (list_len == 0)
        begin
            beat.status = ST_EMPTY;
            if (op == OP_QUERY)
                beat.read_value = -1;
        end
        else if (p >= list_len)
        begin
            beat.status = ST_RANGE;
            if (op == OP_QUERY)
                beat.read_value = -1;
        end
        else
        begin
            held = list_mem[p];
            if (op == OP_QUERY)
                beat.read_value = held;
            else
            begin
                // close the gap, then either drop the tail or park the entry there
                for (int k = p; k < list_len - 1; k++)
                    list_mem[k] = list_mem[k+1];
                if (op == OP_MOVE)
                    list_mem[list_len-1] = held;
                else
                    list_len--;
            end
        end
        best = -1;
        if (list_len > 0)
        begin
            best = list_mem[0];
            for (int k = 1; k < list_len; k++)
                if (list_mem[k] > best)
                    best = list_mem[k];
        end
        beat.entry_count   = CNT_OUT_W'(list_len);
        beat.largest_value = best;
        return beat;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected response beat, expected none actual %0d/%0d/%0d/%0d",
                             $time, rsp.read_value, rsp.entry_count, rsp.largest_value,
                             rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("entry_count", want.entry_count, rsp.entry_count);
                    check_field("largest_value", want.largest_value, rsp.largest_value);
                    check_field("status", want.status, rsp.status);
                end
            end
            if (cmd.valid && cmd.ready)
                expected_rsp_q.push_back(apply_list_op(op_t'(cmd.operation), cmd.position,
                                                       cmd.value));
            pending_count = expected_rsp_q.size();
        end
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// top of the positional list engine testbench: clock, reset, command stimulus,
// response back-pressure, watchdog and verdict
// depends on ple_pkg, ple_if, positional_list_engine_unit and list_engine_checker
module testbench
    import ple_pkg::*;
();

    localparam int CAPACITY     = 64;
    localparam int DATA_WIDTH   = 32;
    // delay of the block from command beat to response beat, in cycles
    localparam int LATENCY      = 14;
    // cycles without any beat before the run is declared hung
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 1300;

    // shapes of the random stimulus
    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ple_cmd_if cmd ();
    ple_rsp_if rsp ();

    int fail_count;
    int pending_count;

    // stimulus bookkeeping
    int burst_left   = 0;
    int shadow_len   = 0;   // list length as the stimulus sees it, only to steer positions
    int items_sent   = 0;
    int directed_cnt = 0;
    int full_hits    = 0;
    int empty_hits   = 0;
    int idle_cycles  = 0;

    always #1 clk = ~clk;

    positional_list_engine_unit #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    list_engine_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // values weighted towards the signed extremes
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // a legal position for the current length most of the time, with ends favoured;
    // otherwise anything the 7-bit field can carry
    function automatic int pick_position(input op_t op, input int noise_pct);
        int top_pos;
        if ($urandom_range(0, 99) < noise_pct)
            return $urandom_range(0, 127);
        top_pos = (op == OP_INSERT) ? shadow_len : shadow_len - 1;
        if (top_pos <= 0)
            return 0;
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return top_pos;
            default: return $urandom_range(0, top_pos);
        endcase
    endfunction

    // one command beat: bursts separated by random gaps, beat taken when ready
    // was seen high between edges and valid was up at the following edge
    task automatic send_cmd(input op_t op, input int position, input logic [VAL_W-1:0] value);
        logic taken;
        if (burst_left == 0)
        begin
            // mostly short bursts, sometimes a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        burst_left--;
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.position  <= POS_W'(position);
        cmd.value     <= value;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cmd.ready;
            @(posedge clk);
        end
        items_sent++;
        // keep the stimulus' idea of the length in step
        if (op == OP_INSERT)
        begin
            if (shadow_len == CAPACITY)
                full_hits++;
            else if (position <= shadow_len)
                shadow_len++;
        end
        else if (shadow_len == 0)
            empty_hits++;
        else if (op == OP_REMOVE && position < shadow_len)
            shadow_len--;
    endtask

    // drop valid and hold off until every outstanding response beat is back
    task automatic wait_drained();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        @(posedge clk);
    endtask

    // response side: back-pressure in modes of random length, including
    // stretches of permanent ready, coin-toss, mostly stalled and a fixed rhythm
    initial
    begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= ($urandom_range(0, 1) == 1);
                2:       rsp.ready <= ($urandom_range(0, 5) == 0);
                default: rsp.ready <= ((mode_left % 7) < 3);
            endcase
        end
    end

    // watchdog: any beat on either channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, giving up", $time, IDLE_LIMIT);
                $display("testbench failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        phase_t kind;
        op_t    op;
        int     phase_no;
        int     extra;
        int     len_mixed;

        cmd.valid     <= 1'b0;
        cmd.operation <= OP_INSERT;
        cmd.position  <= '0;
        cmd.value     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation on the empty list
        send_cmd(OP_QUERY,  0,   32'h0);
        send_cmd(OP_REMOVE, 0,   32'h0);
        send_cmd(OP_MOVE,   5,   32'h0);
        send_cmd(OP_QUERY,  127, 32'h0);
        // insert past the end of an empty list
        send_cmd(OP_INSERT, 1,   32'h1234_5678);
        // build a list from the value extremes, front, tail and middle inserts
        send_cmd(OP_INSERT, 0,   32'h7FFF_FFFF);
        send_cmd(OP_INSERT, 1,   32'h8000_0000);
        send_cmd(OP_INSERT, 0,   32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 1,   32'h0000_0000);
        // read each entry back, then just past the end and at the top of the field
        send_cmd(OP_QUERY,  0,   32'hDEAD_BEEF);
        send_cmd(OP_QUERY,  1,   32'h0);
        send_cmd(OP_QUERY,  2,   32'h0);
        send_cmd(OP_QUERY,  3,   32'h0);
        send_cmd(OP_QUERY,  4,   32'h0);
        send_cmd(OP_QUERY,  127, 32'h0);
        // move the head to the tail, remove the last entry, then remove, move and insert past the end
        send_cmd(OP_MOVE,   0,   32'h0);
        send_cmd(OP_REMOVE, 3,   32'h0);
        send_cmd(OP_REMOVE, 3,   32'h0);
        send_cmd(OP_MOVE,   64,  32'h0);
        send_cmd(OP_INSERT, 64,  32'h0);
        // alternating bit patterns, appended and at the front
        send_cmd(OP_INSERT, 3,   32'h5555_5555);
        send_cmd(OP_INSERT, 0,   32'hAAAA_AAAA);
        directed_cnt = items_sent;

        // hold the sender until the block has answered everything
        wait_drained();

        // random: first a fill to capacity and a drain to empty, then any mix
        phase_no = 0;
        while (items_sent - directed_cnt < RANDOM_ITEMS)
        begin
            if (phase_no == 0)
                kind = PH_FILL;
            else if (phase_no == 1)
                kind = PH_DRAIN;
            else
                kind = phase_t'($urandom_range(0, 2));
            case (kind)
                PH_FILL:
                begin
                    // mostly legal inserts until full, then a few refused ones
                    extra = 3;
                    while (extra > 0)
                    begin
                        if (shadow_len == CAPACITY)
                            extra--;
                        op = ($urandom_range(0, 9) < 8) ? OP_INSERT
                                                        : op_t'($urandom_range(1, 3));
                        send_cmd(op, pick_position(op, 10), pick_value());
                    end
                end
                PH_DRAIN:
                begin
                    // mostly legal removes until empty, then a couple on the empty list
                    extra = 2;
                    while (extra > 0)
                    begin
                        if (shadow_len == 0)
                            extra--;
                        case ($urandom_range(0, 9))
                            0:       op = OP_INSERT;
                            1:       op = OP_QUERY;
                            2:       op = OP_MOVE;
                            default: op = OP_REMOVE;
                        endcase
                        send_cmd(op, pick_position(op, 10), pick_value());
                    end
                end
                default:
                begin
                    // any operation, a quarter of positions unconstrained
                    len_mixed = $urandom_range(30, 120);
                    repeat (len_mixed)
                    begin
                        op = op_t'($urandom_range(0, 3));
                        send_cmd(op, pick_position(op, 25), pick_value());
                    end
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            phase_no++;
        end

        // drain, then keep running past the block's response delay so any stray beat shows
        wait_drained();
        repeat (2 * LATENCY + 4) @(posedge clk);

        $display("%0d commands sent, %0d of them directed, over %0d random phases",
                 items_sent, directed_cnt, phase_no);
        $display("%0d inserts hit a full list, %0d operations hit an empty list",
                 full_hits, empty_hits);
        if (fail_count == 0 && pending_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* positional_list_engine_unit.f */
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_cell.sv
rtl/ple_tree.sv
rtl/positional_list_engine_unit.sv
verif/list_engine_checker.sv
verif/testbench.sv
